// ----- rtl/recency_ordered_id_list_defines.svh -----
// assertion macros shared by the recency list checker
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef RECENCY_ORDERED_ID_LIST_DEFINES_SVH
`define RECENCY_ORDERED_ID_LIST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ROL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ROL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rol_pkg.sv -----
// shared types and constants for the recency-ordered identifier list
// no dependencies
`timescale 1ns / 1ps

package rol_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // classified command handed from front to back
  typedef struct packed {
    logic search;
    logic append;
    logic clear;
    id_t  id;
  } op_t;

endpackage

// ----- rtl/recency_ordered_id_list.sv -----
// Accepted commands enter the op queue; the cell row compares and shifts on
// the queue head combinationally and loads the result register. Throughput:
// one command per cycle while out_stall is low; the two-entry op queue
// absorbs result stalls. Reset clears list count, queue and result valid;
// cell contents are not cleared and are only read below the count.
`timescale 1ns / 1ps

module recency_ordered_id_list (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_entry_count,
  output logic [15:0] out_head_id,
  output logic        out_head_valid,
  output logic        out_found,
  output logic        out_dropped
);

  logic         q_full;
  logic         push;
  rol_pkg::op_t push_op;
  logic         pop;
  logic         pop_valid;
  rol_pkg::op_t pop_op;

  // command decode
  rol_front u_front (
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_id    (in_id),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  // decoupling queue
  rol_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_op    (pop_op)
  );

  // list engine and result register
  rol_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_valid        (pop_valid),
    .op              (pop_op),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_entry_count (out_entry_count),
    .out_head_id     (out_head_id),
    .out_head_valid  (out_head_valid),
    .out_found       (out_found),
    .out_dropped     (out_dropped)
  );

endmodule

// ----- rtl/rol_front.sv -----
// front end: takes input transfers and classifies each command into an op
// depends on rol_pkg
`timescale 1ns / 1ps

module rol_front (
  input  logic           in_valid,
  input  logic [1:0]     in_cmd,
  input  logic [15:0]    in_id,
  output logic           in_stall,
  input  logic           q_full,
  output logic           push,
  output rol_pkg::op_t   push_op
);

  // stall while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // decode the command into search / append / clear actions
  always_comb begin
    push_op        = '0;
    push_op.id     = in_id[rol_pkg::ID_BITS-1:0];
    unique case (rol_pkg::cmd_t'(in_cmd))
      rol_pkg::CMD_APPEND: begin
        push_op.append = 1'b1;
      end
      rol_pkg::CMD_TOUCH: begin
        push_op.search = 1'b1;
        push_op.append = 1'b1;
      end
      rol_pkg::CMD_REMOVE: begin
        push_op.search = 1'b1;
      end
      rol_pkg::CMD_CLEAR: begin
        push_op.clear = 1'b1;
      end
      default: begin
        push_op.clear = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/rol_fifo.sv -----
// short op queue between the front end and the list engine
// depends on rol_pkg
`timescale 1ns / 1ps

module rol_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rol_pkg::op_t   push_op,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output rol_pkg::op_t   pop_op
);

  rol_pkg::op_t                     entries_r [rol_pkg::Q_DEPTH];
  logic [rol_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rol_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rol_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == rol_pkg::QCNT_W'(rol_pkg::Q_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_op    = entries_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rol_pkg::QPTR_W'(rol_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && pop_valid) begin
      rd_ptr_nxt = (rd_ptr_r == rol_pkg::QPTR_W'(rol_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + rol_pkg::QCNT_W'(push) - rol_pkg::QCNT_W'(pop && pop_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/rol_back.sv -----
// list engine: row of identifier cells with parallel compare and shift to head,
// plus the result register; depends on rol_pkg
`timescale 1ns / 1ps

module rol_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           op_valid,
  input  rol_pkg::op_t   op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [4:0]     out_entry_count,
  output logic [15:0]    out_head_id,
  output logic           out_head_valid,
  output logic           out_found,
  output logic           out_dropped
);

  rol_pkg::id_t  slots_r   [rol_pkg::DEPTH];
  rol_pkg::id_t  slots_nxt [rol_pkg::DEPTH];
  rol_pkg::cnt_t cnt_r, cnt_nxt, cnt_mid;
  logic [rol_pkg::DEPTH-1:0] hit;
  logic [rol_pkg::DEPTH-1:0] after;
  logic          seen;
  logic          found;
  logic          drop;
  logic          do_app;
  logic          out_valid_r;
  logic [4:0]    out_cnt_r;
  logic [15:0]   out_head_r;
  logic          out_hv_r;
  logic          out_found_r;
  logic          out_drop_r;
  logic          can_load;

  // result register frees when empty or being taken
  assign can_load = !out_valid_r || !out_stall;
  assign pop      = op_valid && can_load;

  // per-cell compare and first-match prefix
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < rol_pkg::DEPTH; i++) begin
      hit[i]   = op.search && (rol_pkg::CNT_W'(i) < cnt_r) && (slots_r[i] == op.id);
      seen     = seen | hit[i];
      after[i] = seen;
    end
    found = seen;
  end

  // removal shifts cells at and past the match toward the head, then append
  always_comb begin
    cnt_mid = cnt_r - rol_pkg::CNT_W'(found);
    drop    = op.append && (cnt_mid == rol_pkg::CNT_W'(rol_pkg::DEPTH));
    do_app  = op.append && !drop;
    for (int i = 0; i < rol_pkg::DEPTH - 1; i++) begin
      slots_nxt[i] = after[i] ? slots_r[i+1] : slots_r[i];
    end
    slots_nxt[rol_pkg::DEPTH-1] = slots_r[rol_pkg::DEPTH-1];
    for (int i = 0; i < rol_pkg::DEPTH; i++) begin
      if (do_app && (cnt_mid == rol_pkg::CNT_W'(i))) begin
        slots_nxt[i] = op.id;
      end
    end
    if (op.clear) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_mid + rol_pkg::CNT_W'(do_app);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cell contents and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < rol_pkg::DEPTH; i++) begin
        slots_r[i] <= slots_nxt[i];
      end
      out_cnt_r   <= 5'(cnt_nxt);
      out_hv_r    <= (cnt_nxt != '0);
      out_head_r  <= (cnt_nxt != '0) ? 16'(slots_nxt[0]) : 16'd0;
      out_found_r <= found;
      out_drop_r  <= drop;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_count = out_cnt_r;
  assign out_head_id     = out_head_r;
  assign out_head_valid  = out_hv_r;
  assign out_found       = out_found_r;
  assign out_dropped     = out_drop_r;

endmodule

// ----- rtl/rol_checker.sv -----
// port-level checks for the recency list, bound to the top level
// depends on recency_ordered_id_list_defines.svh
`timescale 1ns / 1ps
`include "recency_ordered_id_list_defines.svh"

module rol_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic [15:0] in_id,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_entry_count,
  input logic [15:0] out_head_id,
  input logic        out_head_valid,
  input logic        out_found,
  input logic        out_dropped
);

  // a stalled result holds
  `ROL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_entry_count) && $stable(out_head_id) && $stable(out_found) && $stable(out_dropped), "stalled result changed")

  // head valid tracks a nonzero count
  `ROL_ASSERT_NOW(a_head_valid, out_valid, out_head_valid == (out_entry_count != 5'd0), "head valid disagrees with count")

  // an empty list shows a zero head and a count no greater than the depth
  `ROL_ASSERT_NOW(a_empty_head, out_valid && !out_head_valid, out_head_id == 16'd0 && out_entry_count <= 5'd16, "bad empty head or count")

  // a match always makes room, so found and dropped never coincide
  `ROL_ASSERT_NOW(a_found_drop, out_valid, !(out_found && out_dropped), "found and dropped together")

endmodule

bind recency_ordered_id_list rol_checker u_rol_checker (.*);

// ----- bench/recency_list_checker.sv -----
// result checker for the recency-ordered identifier list
// depends on rol_pkg; watches both channels and counts mismatches
`timescale 1ns / 1ps

module recency_list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_entry_count,
  input  logic [15:0] out_head_id,
  input  logic        out_head_valid,
  input  logic        out_found,
  input  logic        out_dropped,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [4:0]   count;
    rol_pkg::id_t head;
    logic         head_valid;
    logic         found;
    logic         dropped;
  } list_status_t;

  // shadow copy of the list, oldest entry at index 0
  rol_pkg::id_t shadow_ids [rol_pkg::DEPTH];
  int           shadow_len = 0;
  list_status_t results_due [$];
  int           mismatches = 0;
  int           outstanding = 0;

  assign fails   = mismatches;
  assign pending = outstanding;

  // update the shadow list for one command and give the status it reports
  function automatic list_status_t apply_command(rol_pkg::cmd_t op, rol_pkg::id_t ident);
    list_status_t st;
    int           hit;
    st      = '0;
    hit     = -1;
    if (op == rol_pkg::CMD_TOUCH || op == rol_pkg::CMD_REMOVE) begin
      // only the oldest copy of a duplicate is taken out
      for (int i = 0; i < shadow_len; i++) begin
        if (hit < 0 && shadow_ids[i] == ident) hit = i;
      end
      if (hit >= 0) begin
        st.found = 1'b1;
        for (int i = hit; i + 1 < shadow_len; i++) shadow_ids[i] = shadow_ids[i + 1];
        shadow_len--;
      end
    end
    if (op == rol_pkg::CMD_APPEND || op == rol_pkg::CMD_TOUCH) begin
      if (shadow_len >= rol_pkg::DEPTH) begin
        st.dropped = 1'b1;
      end else begin
        shadow_ids[shadow_len] = ident;
        shadow_len++;
      end
    end
    if (op == rol_pkg::CMD_CLEAR) shadow_len = 0;
    st.count      = shadow_len[4:0];
    st.head_valid = (shadow_len > 0);
    st.head       = (shadow_len > 0) ? shadow_ids[0] : '0;
    return st;
  endfunction

  function automatic int check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  // predict on each command transfer, compare on each result transfer
  always @(posedge clk) begin : watch
    list_status_t want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      shadow_len = 0;
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(apply_command(rol_pkg::cmd_t'(in_cmd), in_id));
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got count %0d head %0h",
                   $time, out_entry_count, out_head_id);
          errs = 1;
        end else begin
          want = results_due.pop_front();
          errs += check_field("entry_count", 16'(want.count), 16'(out_entry_count));
          errs += check_field("head_id", want.head, out_head_id);
          errs += check_field("head_valid", 16'(want.head_valid), 16'(out_head_valid));
          errs += check_field("found", 16'(want.found), 16'(out_found));
          errs += check_field("dropped", 16'(want.dropped), 16'(out_dropped));
        end
      end
    end
    mismatches  <= mismatches + errs;
    outstanding <= results_due.size();
  end

endmodule

// ----- bench/tb.sv -----
// stimulus and verdict for the recency-ordered identifier list
// depends on rol_pkg, recency_ordered_id_list and recency_list_checker
`timescale 1ns / 1ps

module tb;

  localparam int N_RANDOM  = 1900;
  localparam int MAX_CYCLE = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [15:0] in_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_entry_count;
  logic [15:0] out_head_id;
  logic        out_head_valid;
  logic        out_found;
  logic        out_dropped;
  int          fails;
  int          pending;
  int          cycles = 0;
  logic        calm = 1'b0;

  always #6 clk = ~clk;

  recency_ordered_id_list uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_id(in_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_count(out_entry_count), .out_head_id(out_head_id),
    .out_head_valid(out_head_valid), .out_found(out_found), .out_dropped(out_dropped)
  );

  recency_list_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd), .in_id(in_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_entry_count(out_entry_count), .out_head_id(out_head_id),
    .out_head_valid(out_head_valid), .out_found(out_found), .out_dropped(out_dropped),
    .fails(fails), .pending(pending)
  );

  // result-side back-pressure, off during the calm stretch
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("FAIL recency_ordered_id_list");
      $finish;
    end
  end

  // one command transfer, with random idle cycles ahead of it outside the calm stretch
  task automatic send(input rol_pkg::cmd_t op, input rol_pkg::id_t ident);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= op;
    in_id    <= ident;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // command mix depends on whether the segment fills, drains or balances
  function automatic rol_pkg::cmd_t pick_cmd(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return rol_pkg::CMD_CLEAR;
    case (mode)
      0:       return (r < 55) ? rol_pkg::CMD_APPEND :
                      (r < 85) ? rol_pkg::CMD_TOUCH : rol_pkg::CMD_REMOVE;
      1:       return (r < 20) ? rol_pkg::CMD_APPEND :
                      (r < 40) ? rol_pkg::CMD_TOUCH : rol_pkg::CMD_REMOVE;
      default: return (r < 35) ? rol_pkg::CMD_APPEND :
                      (r < 70) ? rol_pkg::CMD_TOUCH : rol_pkg::CMD_REMOVE;
    endcase
  endfunction

  initial begin
    int           mode;
    int           span;
    int           r;
    rol_pkg::id_t base;
    rol_pkg::id_t ident;
    mode = 0;
    span = 8;
    base = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, duplicates, fill to full, drops, matches, clear
    send(rol_pkg::CMD_CLEAR, 16'hFFFF);
    send(rol_pkg::CMD_REMOVE, 16'h0000);
    send(rol_pkg::CMD_TOUCH, 16'hFFFF);
    send(rol_pkg::CMD_APPEND, 16'h0000);
    send(rol_pkg::CMD_APPEND, 16'hFFFF);
    send(rol_pkg::CMD_TOUCH, 16'hFFFF);
    for (int k = 1; k <= 13; k++) send(rol_pkg::CMD_APPEND, rol_pkg::id_t'(k * 16'h1111));
    send(rol_pkg::CMD_APPEND, 16'h8000);
    send(rol_pkg::CMD_TOUCH, 16'h7FFF);
    send(rol_pkg::CMD_TOUCH, 16'h0000);
    send(rol_pkg::CMD_REMOVE, 16'h1234);
    send(rol_pkg::CMD_REMOVE, 16'hFFFF);
    send(rol_pkg::CMD_CLEAR, 16'h5A5A);

    // random: ids mostly from a small pool so that matches and duplicates occur
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(3, 24);
        base = rol_pkg::id_t'($urandom_range(0, 65535));
      end
      calm <= (n >= 700 && n < 1000);
      r = $urandom_range(0, 99);
      if (r < 75)      ident = base + rol_pkg::id_t'($urandom_range(0, span));
      else if (r < 88) ident = rol_pkg::id_t'($urandom_range(0, 65535));
      else if (r < 94) ident = 16'hFFFF;
      else             ident = 16'h0000;
      send(pick_cmd(mode), ident);
    end
    in_valid <= 1'b0;

    // drain, then keep watching to catch stray results
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("PASS recency_ordered_id_list");
    end else begin
      $display("FAIL recency_ordered_id_list");
    end
    $finish;
  end

endmodule
